// ===== design/bcec_pkg.sv =====
// Package: transaction types, constants and helper functions for the BCD calendar converter.
`timescale 1ns / 1ps

package bcec_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] epoch_seconds;
    logic [7:0]  in_bcd_sec;
    logic [7:0]  in_bcd_min;
    logic [7:0]  in_bcd_hour;
    logic [7:0]  in_bcd_mday;
    logic [7:0]  in_bcd_mon;
    logic [7:0]  in_bcd_year;
  } req_t;

  typedef struct packed {
    logic [31:0] out_seconds;
    logic [6:0]  out_bcd_sec;
    logic [6:0]  out_bcd_min;
    logic [5:0]  out_bcd_hour;
    logic [5:0]  out_bcd_mday;
    logic [4:0]  out_bcd_mon;
    logic [7:0]  out_bcd_year;
    logic        bad_month;
  } res_t;

  localparam logic        KIND_TO_SECS   = 1'b0;
  localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN   = 32'd60;
  localparam logic [31:0] SECS_YEAR      = 32'd31536000;
  localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;
  localparam logic [31:0] DAYS_YEAR      = 32'd365;
  localparam logic [31:0] DAYS_LEAP_YEAR = 32'd366;
  localparam logic [7:0]  YEAR_WINDOW    = 8'd70;
  localparam logic [7:0]  YEAR_OFF_20XX  = 8'd30;
  localparam logic [3:0]  DEC_MAX        = 4'd9;

  // year offset from 1970; leap when 1970 + off is divisible by four
  function automatic logic is_leap(input logic [7:0] off);
    is_leap = (off[1:0] == 2'd2);
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    unique case (mon)
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    days_in_month = d;
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    from_bcd = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
  endfunction

  // valid for v below 70
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0] r;
    logic [3:0] t;
    r = v;
    t = 4'd0;
    for (int i = 0; i < 6; i++) begin
      if (r >= 7'd10) begin
        r = r - 7'd10;
        t = t + 4'd1;
      end
    end
    to_bcd = {t, r[3:0]};
  endfunction

endpackage

// ===== design/bcd_calendar_epoch_converter_top.sv =====
// Top level: BCD calendar to/from epoch seconds converter on one shared adder.
`timescale 1ns / 1ps
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. req_i.kind selects BCD-to-seconds (0) or seconds-to-BCD (1).
// Result channel: res_o is valid for exactly one cycle while done_o is high;
// the receiver cannot stall it. A new command may be issued in that cycle.
// All work runs through one 32-bit add/subtract unit under a sequencer.
// Kind 0: one add per whole year since 1970, one per month before the
//   given month, then day, hour, minute and second, then the output step.
// Kind 1: restoring division by 86400 into a 16-bit day count, one
//   subtract per elapsed year, one per elapsed month, then the hour/minute
//   split by restoring division and the output step.
// A bad month in kind 0 goes straight to the output step with bad_month set.
// Reset (rst_ni low) abandons any transaction in flight; no result issues.
//
module bcd_calendar_epoch_converter_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bcec_pkg::req_t req_i,
  output logic          done_o,
  output bcec_pkg::res_t res_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_K0_YEAR = 4'd1;
  localparam logic [3:0] S_K0_MON  = 4'd2;
  localparam logic [3:0] S_K0_DAY  = 4'd3;
  localparam logic [3:0] S_K0_HOUR = 4'd4;
  localparam logic [3:0] S_K0_MIN  = 4'd5;
  localparam logic [3:0] S_K0_SEC  = 4'd6;
  localparam logic [3:0] S_K1_DIV  = 4'd7;
  localparam logic [3:0] S_K1_YEAR = 4'd8;
  localparam logic [3:0] S_K1_MON  = 4'd9;
  localparam logic [3:0] S_K1_HOUR = 4'd10;
  localparam logic [3:0] S_K1_MIN  = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0]  state_q, state_d;
  logic        done_q, done_d;
  logic        kind_q, kind_d;
  logic        bad_q, bad_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] quo_q, quo_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  yoff_q, yoff_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  hq_q, hq_d;
  logic [5:0]  mq_q, mq_d;
  logic [3:0]  yt_q, yt_d;
  logic [3:0]  yu_q, yu_d;
  logic [6:0]  sec_q, sec_d;
  logic [6:0]  min_q, min_d;
  logic [5:0]  hour_q, hour_d;
  logic [5:0]  mday_q, mday_d;
  logic [3:0]  tmon_q, tmon_d;
  logic [6:0]  tyr_q, tyr_d;
  bcec_pkg::res_t res_q, res_d;

  logic [31:0] op_a, op_b;
  logic        op_sub;
  logic [32:0] sum;
  logic        ge;

  logic [7:0] dec_sec, dec_min, dec_hour, dec_mday, dec_mon, dec_year, off_year;
  logic [7:0] bcd_s, bcd_m, bcd_h, bcd_d, bcd_mo;
  logic [6:0] mday_p1;

  assign dec_sec  = bcec_pkg::from_bcd(req_i.in_bcd_sec & 8'h7F);
  assign dec_min  = bcec_pkg::from_bcd(req_i.in_bcd_min & 8'h7F);
  assign dec_hour = bcec_pkg::from_bcd(req_i.in_bcd_hour & 8'h3F);
  assign dec_mday = bcec_pkg::from_bcd(req_i.in_bcd_mday & 8'h3F);
  assign dec_mon  = bcec_pkg::from_bcd(req_i.in_bcd_mon & 8'h3F);
  assign dec_year = bcec_pkg::from_bcd(req_i.in_bcd_year);
  assign off_year = (dec_year < bcec_pkg::YEAR_WINDOW) ?
                    dec_year + bcec_pkg::YEAR_OFF_20XX :
                    dec_year - bcec_pkg::YEAR_WINDOW;

  assign mday_p1 = {2'd0, quo_q[4:0]} + 7'd1;
  assign bcd_s   = bcec_pkg::to_bcd({1'b0, acc_q[5:0]});
  assign bcd_m   = bcec_pkg::to_bcd({1'b0, mq_q});
  assign bcd_h   = bcec_pkg::to_bcd({2'd0, hq_q});
  assign bcd_d   = bcec_pkg::to_bcd(mday_p1);
  assign bcd_mo  = bcec_pkg::to_bcd({3'd0, mon_q});

  // shared add/subtract unit
  always_comb begin
    op_a   = acc_q;
    op_b   = 32'd0;
    op_sub = 1'b0;
    unique case (state_q)
      S_K0_YEAR: op_b = bcec_pkg::is_leap(yoff_q) ? bcec_pkg::SECS_LEAP_YEAR :
                                                     bcec_pkg::SECS_YEAR;
      S_K0_MON:  op_b = {27'd0, bcec_pkg::days_in_month(mon_q,
                          bcec_pkg::is_leap({1'b0, tyr_q}))} * bcec_pkg::SECS_PER_DAY;
      S_K0_DAY:  op_b = ({26'd0, mday_q} - 32'd1) * bcec_pkg::SECS_PER_DAY;
      S_K0_HOUR: op_b = {26'd0, hour_q} * bcec_pkg::SECS_PER_HOUR;
      S_K0_MIN:  op_b = {25'd0, min_q} * bcec_pkg::SECS_PER_MIN;
      S_K0_SEC:  op_b = {25'd0, sec_q};
      S_K1_DIV: begin
        op_b   = bcec_pkg::SECS_PER_DAY << step_q;
        op_sub = 1'b1;
      end
      S_K1_YEAR: begin
        op_a   = {16'd0, quo_q};
        op_b   = bcec_pkg::is_leap(yoff_q) ? bcec_pkg::DAYS_LEAP_YEAR :
                                              bcec_pkg::DAYS_YEAR;
        op_sub = 1'b1;
      end
      S_K1_MON: begin
        op_a   = {16'd0, quo_q};
        op_b   = {27'd0, bcec_pkg::days_in_month(mon_q, bcec_pkg::is_leap(yoff_q))};
        op_sub = 1'b1;
      end
      S_K1_HOUR: begin
        op_b   = bcec_pkg::SECS_PER_HOUR << step_q[2:0];
        op_sub = 1'b1;
      end
      S_K1_MIN: begin
        op_b   = bcec_pkg::SECS_PER_MIN << step_q[2:0];
        op_sub = 1'b1;
      end
      default: op_b = 32'd0;
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + {32'd0, op_sub};
  assign ge  = sum[32];

  // sequencer
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    kind_d  = kind_q;
    bad_d   = bad_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    step_d  = step_q;
    yoff_d  = yoff_q;
    mon_d   = mon_q;
    hq_d    = hq_q;
    mq_d    = mq_q;
    yt_d    = yt_q;
    yu_d    = yu_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    mday_d  = mday_q;
    tmon_d  = tmon_q;
    tyr_d   = tyr_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d = req_i.kind;
          bad_d  = 1'b0;
          acc_d  = 32'd0;
          yoff_d = 8'd0;
          mon_d  = 4'd1;
          if (req_i.kind == bcec_pkg::KIND_TO_SECS) begin
            sec_d  = dec_sec[6:0];
            min_d  = dec_min[6:0];
            hour_d = dec_hour[5:0];
            mday_d = dec_mday[5:0];
            tmon_d = dec_mon[3:0];
            tyr_d  = off_year[6:0];
            if (dec_mon < 8'd1 || dec_mon > 8'd12) begin
              bad_d   = 1'b1;
              state_d = S_FIN;
            end else begin
              state_d = S_K0_YEAR;
            end
          end else begin
            acc_d   = req_i.epoch_seconds;
            quo_d   = 16'd0;
            step_d  = 4'd15;
            yt_d    = 4'd7;
            yu_d    = 4'd0;
            hq_d    = 5'd0;
            mq_d    = 6'd0;
            state_d = S_K1_DIV;
          end
        end
      end
      S_K0_YEAR: begin
        if (yoff_q == {1'b0, tyr_q}) begin
          state_d = S_K0_MON;
        end else begin
          acc_d  = sum[31:0];
          yoff_d = yoff_q + 8'd1;
        end
      end
      S_K0_MON: begin
        if (mon_q == tmon_q) begin
          state_d = S_K0_DAY;
        end else begin
          acc_d = sum[31:0];
          mon_d = mon_q + 4'd1;
        end
      end
      S_K0_DAY: begin
        acc_d   = sum[31:0];
        state_d = S_K0_HOUR;
      end
      S_K0_HOUR: begin
        acc_d   = sum[31:0];
        state_d = S_K0_MIN;
      end
      S_K0_MIN: begin
        acc_d   = sum[31:0];
        state_d = S_K0_SEC;
      end
      S_K0_SEC: begin
        acc_d   = sum[31:0];
        state_d = S_FIN;
      end
      S_K1_DIV: begin
        if (ge) begin
          acc_d         = sum[31:0];
          quo_d[step_q] = 1'b1;
        end
        if (step_q == 4'd0) begin
          state_d = S_K1_YEAR;
        end else begin
          step_d = step_q - 4'd1;
        end
      end
      S_K1_YEAR: begin
        if (ge) begin
          quo_d  = sum[15:0];
          yoff_d = yoff_q + 8'd1;
          if (yu_q == bcec_pkg::DEC_MAX) begin
            yu_d = 4'd0;
            yt_d = (yt_q == bcec_pkg::DEC_MAX) ? 4'd0 : yt_q + 4'd1;
          end else begin
            yu_d = yu_q + 4'd1;
          end
        end else begin
          state_d = S_K1_MON;
        end
      end
      S_K1_MON: begin
        if (mon_q != 4'd12 && ge) begin
          quo_d = sum[15:0];
          mon_d = mon_q + 4'd1;
        end else begin
          step_d  = 4'd4;
          state_d = S_K1_HOUR;
        end
      end
      S_K1_HOUR: begin
        if (ge) begin
          acc_d             = sum[31:0];
          hq_d[step_q[2:0]] = 1'b1;
        end
        if (step_q == 4'd0) begin
          step_d  = 4'd5;
          state_d = S_K1_MIN;
        end else begin
          step_d = step_q - 4'd1;
        end
      end
      S_K1_MIN: begin
        if (ge) begin
          acc_d             = sum[31:0];
          mq_d[step_q[2:0]] = 1'b1;
        end
        if (step_q == 4'd0) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q - 4'd1;
        end
      end
      S_FIN: begin
        res_d = '0;
        if (kind_q == bcec_pkg::KIND_TO_SECS) begin
          res_d.out_seconds = acc_q;
          res_d.bad_month   = bad_q;
        end else begin
          res_d.out_bcd_sec  = bcd_s[6:0];
          res_d.out_bcd_min  = bcd_m[6:0];
          res_d.out_bcd_hour = bcd_h[5:0];
          res_d.out_bcd_mday = bcd_d[5:0];
          res_d.out_bcd_mon  = bcd_mo[4:0];
          res_d.out_bcd_year = {yt_q, yu_q};
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    bad_q  <= bad_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    yoff_q <= yoff_d;
    mon_q  <= mon_d;
    hq_q   <= hq_d;
    mq_q   <= mq_d;
    yt_q   <= yt_d;
    yu_q   <= yu_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    mday_q <= mday_d;
    tmon_q <= tmon_d;
    tyr_q  <= tyr_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
